FILE: rtl/bmv_pkg.sv
// bmv_pkg: shared types and constants for the batched matrix-vector mac
// used by every module of the block; no dependencies

package bmv_pkg;

  // default largest block size
  localparam int unsigned MaxDimDefault = 64;

  // fixed field widths
  localparam int unsigned ValW  = 16;
  localparam int unsigned ProdW = 2 * ValW;
  localparam int unsigned AccW  = 38;
  localparam int unsigned RowW  = 6;
  localparam int unsigned BlkW  = 16;
  localparam int unsigned DimRegW = 7;

  // stream data widths, padded to whole bytes
  localparam int unsigned OutFieldsW = AccW + RowW + BlkW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_DIM         = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } reg_idx_e;

  // input opcode
  typedef enum logic {
    OP_LOAD_VEC = 1'b0,
    OP_MATRIX   = 1'b1
  } opcode_e;

  // row bookkeeping carried along with each matrix element
  typedef struct packed {
    logic            emit;
    logic [RowW-1:0] row_index;
    logic [BlkW-1:0] block_index;
    logic            last;
    logic            batch_done;
  } mac_tag_t;

endpackage

FILE: rtl/batched_matrix_vector_mac_top.sv
// a row's sum reaches the output register after its last element passes stages a and b
// throughput: one item (vector load or matrix element) per cycle; stalls only when the
//   output register holds a row sum the sink has not taken, the next row end waits behind it
//   in the product stage and one more matrix element sits in the input stage
// reset: counters, accumulator and valid flags cleared, dim and block_count set to 1;
//   the vector store is not cleared and holds garbage until loaded

module batched_matrix_vector_mac_top
  import bmv_pkg::*;
#(
  parameter int unsigned MAX_DIM = MaxDimDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // apb configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ValW-1:0]     s_axis_tdata,  // [15:0] value
  input  logic                s_axis_tuser,  // [0] opcode
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [37:0] row_sum, [43:38] row_index,
                                             // [59:44] block_index, [63:60] zero
  output logic                m_axis_tlast,  // last
  output logic                m_axis_tuser   // [0] batch_done
);

  localparam int unsigned IdxW = $clog2(MAX_DIM);

  logic [DimRegW-1:0]     dim_q;
  logic [BlkW-1:0]        block_count_q;
  logic                   cfg_wr;
  reg_idx_e               cfg_idx;
  logic                   accept, load_acc, mac_acc;
  logic [IdxW-1:0]        wr_addr, rd_addr;
  mac_tag_t               in_tag, out_tag;
  logic signed [ValW-1:0] vec_data;
  logic signed [AccW-1:0] out_sum;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q         <= DimRegW'(1);
      block_count_q <= BlkW'(1);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DIM:         dim_q         <= pwdata[DimRegW-1:0];
        REG_BLOCK_COUNT: block_count_q <= pwdata[BlkW-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DIM:         prdata = ApbDataW'(dim_q);
      REG_BLOCK_COUNT: prdata = ApbDataW'(block_count_q);
      default:         prdata = '0;
    endcase
  end

  // input handshake split by opcode
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign load_acc = accept && (opcode_e'(s_axis_tuser) == OP_LOAD_VEC);
  assign mac_acc  = accept && (opcode_e'(s_axis_tuser) == OP_MATRIX);

  bmv_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dim_i         (dim_q),
    .block_count_i (block_count_q),
    .load_i        (load_acc),
    .mac_i         (mac_acc),
    .wr_addr_o     (wr_addr),
    .rd_addr_o     (rd_addr),
    .tag_o         (in_tag)
  );

  bmv_vec_store #(
    .MAX_DIM (MAX_DIM)
  ) u_vec_store (
    .clk_i     (clk_i),
    .wr_en_i   (load_acc),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (mac_acc),
    .rd_addr_i (rd_addr),
    .rd_data_o (vec_data)
  );

  bmv_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mac_acc),
    .in_value_i  (s_axis_tdata),
    .in_tag_i    (in_tag),
    .vec_data_i  (vec_data),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sum_o   (out_sum),
    .out_tag_o   (out_tag)
  );

  // result packing
  assign m_axis_tdata = OutDataW'({out_tag.block_index, out_tag.row_index, out_sum});
  assign m_axis_tlast = out_tag.last;
  assign m_axis_tuser = out_tag.batch_done;

  // input stalls only behind a result the sink is holding off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // end of batch always falls on the last row of a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("batch_done without last");

endmodule

FILE: rtl/bmv_vec_store.sv
// bmv_vec_store: vector element store, one write and one registered read port
// depends on bmv_pkg for the element width

module bmv_vec_store
  import bmv_pkg::*;
#(
  parameter int unsigned MAX_DIM = MaxDimDefault,
  localparam int unsigned IdxW = $clog2(MAX_DIM)
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [IdxW-1:0]        wr_addr_i,
  input  logic signed [ValW-1:0] wr_data_i,
  input  logic                   rd_en_i,
  input  logic [IdxW-1:0]        rd_addr_i,
  output logic signed [ValW-1:0] rd_data_o
);

  logic signed [ValW-1:0] mem [MAX_DIM];
  logic signed [ValW-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/bmv_ctrl.sv
// bmv_ctrl: load pointer, column, row and block counters
// depends on bmv_pkg for the row tag struct and widths

module bmv_ctrl
  import bmv_pkg::*;
#(
  parameter int unsigned MAX_DIM = MaxDimDefault,
  localparam int unsigned IdxW = $clog2(MAX_DIM),
  localparam int unsigned CntW = IdxW + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [DimRegW-1:0] dim_i,
  input  logic [BlkW-1:0]    block_count_i,
  input  logic               load_i,
  input  logic               mac_i,
  output logic [IdxW-1:0]    wr_addr_o,
  output logic [IdxW-1:0]    rd_addr_o,
  output mac_tag_t           tag_o
);

  logic [IdxW-1:0] lp_q, lp_d;
  logic [IdxW-1:0] cc_q, cc_d;
  logic [IdxW-1:0] rc_q, rc_d;
  logic [BlkW-1:0] bc_q, bc_d;
  logic [CntW-1:0] dim_eff;
  logic [BlkW:0]   blk_eff;
  logic [CntW-1:0] lp_inc, cc_inc, rc_inc;
  logic [BlkW:0]   bc_inc;
  logic            row_end, last_row, last_blk;

  // effective limits: zero means one, dim capped at the store depth
  always_comb begin
    if (dim_i == '0) begin
      dim_eff = CntW'(1);
    end else if (32'(dim_i) > MAX_DIM) begin
      dim_eff = CntW'(MAX_DIM);
    end else begin
      dim_eff = CntW'(dim_i);
    end
    blk_eff = (block_count_i == '0) ? (BlkW+1)'(1) : {1'b0, block_count_i};
  end

  // end-of-count tests
  assign lp_inc   = {1'b0, lp_q} + CntW'(1);
  assign cc_inc   = {1'b0, cc_q} + CntW'(1);
  assign rc_inc   = {1'b0, rc_q} + CntW'(1);
  assign bc_inc   = {1'b0, bc_q} + (BlkW+1)'(1);
  assign row_end  = cc_inc >= dim_eff;
  assign last_row = rc_inc >= dim_eff;
  assign last_blk = bc_inc >= blk_eff;

  // counter next values
  always_comb begin
    lp_d = lp_q;
    cc_d = cc_q;
    rc_d = rc_q;
    bc_d = bc_q;
    if (load_i) begin
      lp_d = (lp_inc >= dim_eff) ? '0 : lp_inc[IdxW-1:0];
    end
    if (mac_i) begin
      if (!row_end) begin
        cc_d = cc_inc[IdxW-1:0];
      end else begin
        cc_d = '0;
        if (last_row) begin
          rc_d = '0;
          lp_d = '0;
          bc_d = last_blk ? '0 : bc_inc[BlkW-1:0];
        end else begin
          rc_d = rc_inc[IdxW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
      cc_q <= '0;
      rc_q <= '0;
      bc_q <= '0;
    end else begin
      lp_q <= lp_d;
      cc_q <= cc_d;
      rc_q <= rc_d;
      bc_q <= bc_d;
    end
  end

  // store addresses and row tag for the element being accepted
  assign wr_addr_o          = lp_q;
  assign rd_addr_o          = cc_q;
  assign tag_o.emit         = row_end;
  assign tag_o.row_index    = RowW'(rc_q);
  assign tag_o.block_index  = bc_q;
  assign tag_o.last         = last_row;
  assign tag_o.batch_done   = last_row && last_blk;

endmodule

FILE: rtl/bmv_mac.sv
// bmv_mac: input stage, multiply stage, saturating accumulator and output register
// depends on bmv_pkg for widths and the row tag struct

module bmv_mac
  import bmv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic signed [ValW-1:0] in_value_i,
  input  mac_tag_t               in_tag_i,
  input  logic signed [ValW-1:0] vec_data_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [AccW-1:0] out_sum_o,
  output mac_tag_t               out_tag_o
);

  logic                    valid_a_q;
  logic signed [ValW-1:0]  val_a_q;
  mac_tag_t                tag_a_q;
  logic                    valid_b_q;
  logic signed [ProdW-1:0] prod_b_q;
  mac_tag_t                tag_b_q;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                    out_valid_q;
  logic signed [AccW-1:0]  out_sum_q;
  mac_tag_t                out_tag_q;
  logic                    out_free, move_b, ready_b;
  logic signed [AccW:0]    sum_wide;
  logic signed [AccW-1:0]  sum_sat;

  // stage handshake: only row-end items need the output register
  assign out_free = !out_valid_q || out_ready_i;
  assign move_b   = valid_b_q && (!tag_b_q.emit || out_free);
  assign ready_b  = !valid_b_q || move_b;
  assign ready_o  = !valid_a_q || ready_b;

  // stage a: element value and tag, vector element read alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (ready_o) begin
      valid_a_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && in_valid_i) begin
      val_a_q <= in_value_i;
      tag_a_q <= in_tag_i;
    end
  end

  // stage b: product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (ready_b) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && valid_a_q) begin
      prod_b_q <= val_a_q * vec_data_i;
      tag_b_q  <= tag_a_q;
    end
  end

  // saturating accumulate
  always_comb begin
    sum_wide = {acc_q[AccW-1], acc_q} + (AccW+1)'(prod_b_q);
    if (sum_wide[AccW] != sum_wide[AccW-1]) begin
      sum_sat = sum_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[AccW-1:0];
    end
    acc_d = acc_q;
    if (move_b) begin
      acc_d = tag_b_q.emit ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move_b && tag_b_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_b && tag_b_q.emit) begin
      out_sum_q <= sum_sat;
      out_tag_q <= tag_b_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_sum_o   = out_sum_q;
  assign out_tag_o   = out_tag_q;

endmodule
